FILE: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/trcs_pkg.sv
// -----------------------------------------------------------------------------
// TX ring chunk scheduler package
// Command and register codes, chunk limits and payload types.
// -----------------------------------------------------------------------------
package trcs_pkg;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_DONE  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic CFG_MAX_CHUNK = 1'b0;
	localparam logic CFG_SEVEN_BIT = 1'b1;

	localparam logic [8:0] CHUNK_MIN       = 9'd16;
	localparam logic [8:0] CHUNK_MAX       = 9'd256;
	localparam logic [8:0] MAX_CHUNK_RESET = 9'd16;
	localparam logic [7:0] SEVEN_BIT_MASK  = 8'h7f;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data;
		logic [9:0] index;
	} item_t;

	typedef struct packed {
		logic       accepted;
		logic       chunk_started;
		logic [9:0] chunk_start;
		logic [8:0] chunk_len;
		logic       busy_res;
		logic [9:0] free_space;
		logic [7:0] read_data;
	} result_t;

endpackage

FILE: rtl/tx_ring_chunk_scheduler.sv
// -----------------------------------------------------------------------------
// TX ring chunk scheduler
// Transmit byte ring (one slot kept empty) that hands out chunks to a mover.
// -----------------------------------------------------------------------------
//  channel   ports                               transfer when
//  item      start, busy, item                   start && !busy
//  result    result_valid, result                result_valid (no stall)
//  config    cfg_valid, cfg_ready, cfg_index,    cfg_valid && cfg_ready
//            cfg_data
//
//  One item per cycle; its result appears in the cycle after the transfer.
//  Pointer update and chunk start are formed combinationally and registered
//  at the transfer; the byte read is the registered read port of the ring RAM.
//  busy and cfg_ready are constant; no clearing pass after reset.
//  Reset clears pointers, chunk state and registers; RAM contents stay.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module tx_ring_chunk_scheduler
	import trcs_pkg::*;
#(
	parameter int BUF_LEN = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	output logic       result_valid,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data
);

	localparam int AW = $clog2(BUF_LEN);
	localparam int SW = (AW + 1 > 10) ? AW + 1 : 10;

	logic [AW-1:0] head_q, tail_q;
	logic [8:0]    len_q;
	logic          inflight_q;
	logic [8:0]    max_chunk_q;
	logic          seven_q;

	logic          res_valid_s1;
	logic          rd_en_s1;
	result_t       res_s1;
	logic [7:0]    ram_rdata;

	function automatic logic [AW-1:0] space_of(input logic [AW-1:0] h,
		input logic [AW-1:0] t);
		if (h >= t)
			return AW'(BUF_LEN - 1) - (h - t);
		return t - h - AW'(1);
	endfunction

	logic          take, wr, dn, rd, st;
	logic [AW-1:0] space_cur;
	logic [AW-1:0] head_a, tail_a;
	logic [8:0]    len_a, lim, new_len, len_n;
	logic          inflight_a, inflight_n;
	logic [SW-1:0] tail_sum, stop, span;
	logic [7:0]    wdata;
	result_t       res_n;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	always_comb begin
		space_cur = space_of(head_q, tail_q);
		wr = take && (item.cmd == CMD_WRITE) && (space_cur != '0);
		dn = take && (item.cmd == CMD_DONE) && inflight_q;
		rd = take && (item.cmd == CMD_READ) && (32'(item.index) < 32'(BUF_LEN));
		wdata = seven_q ? (item.data & SEVEN_BIT_MASK) : item.data;

		head_a = head_q;
		if (wr) begin
			head_a = (head_q == AW'(BUF_LEN - 1)) ? '0 : head_q + AW'(1);
		end

		tail_sum   = SW'(tail_q) + SW'(len_q);
		tail_a     = tail_q;
		len_a      = len_q;
		inflight_a = inflight_q;
		if (dn) begin
			tail_a     = (tail_sum >= SW'(BUF_LEN)) ? '0 : AW'(tail_sum);
			len_a      = '0;
			inflight_a = 1'b0;
		end

		priority if (max_chunk_q < CHUNK_MIN) begin
			lim = CHUNK_MIN;
		end else if (max_chunk_q > CHUNK_MAX) begin
			lim = CHUNK_MAX;
		end else begin
			lim = max_chunk_q;
		end

		st      = take && !inflight_a && (head_a != tail_a);
		stop    = (head_a <= tail_a) ? SW'(BUF_LEN) : SW'(head_a);
		span    = stop - SW'(tail_a);
		new_len = (span > SW'(lim)) ? lim : 9'(span);

		len_n      = st ? new_len : len_a;
		inflight_n = st || inflight_a;

		res_n.accepted      = wr;
		res_n.chunk_started = st;
		res_n.chunk_start   = inflight_n ? 10'(tail_a) : '0;
		res_n.chunk_len     = inflight_n ? len_n : '0;
		res_n.busy_res      = inflight_n;
		res_n.free_space    = 10'(space_of(head_a, tail_a));
		res_n.read_data     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			len_q        <= '0;
			inflight_q   <= 1'b0;
			res_valid_s1 <= 1'b0;
			rd_en_s1     <= 1'b0;
		end else begin
			res_valid_s1 <= take;
			rd_en_s1     <= rd;
			if (take) begin
				head_q     <= head_a;
				tail_q     <= tail_a;
				len_q      <= len_n;
				inflight_q <= inflight_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= MAX_CHUNK_RESET;
			seven_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_CHUNK: max_chunk_q <= cfg_data;
				CFG_SEVEN_BIT: seven_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	trcs_ram #(
		.WIDTH(8),
		.DEPTH(BUF_LEN)
	) u_ram (
		.clk  (clk),
		.we   (wr),
		.waddr(head_q),
		.wdata(wdata),
		.re   (rd),
		.raddr(AW'(item.index)),
		.rdata(ram_rdata)
	);

	assign result_valid = res_valid_s1;

	always_comb begin
		result           = res_s1;
		result.read_data = rd_en_s1 ? ram_rdata : '0;
	end

	`ASSERT_HOLDS(a_idle_len_zero, clk, arst_n, inflight_q || (len_q == '0))
	`ASSERT_HOLDS(a_chunk_len_range, clk, arst_n,
		!inflight_q || ((len_q != '0) && (len_q <= CHUNK_MAX)))
	`ASSERT_HOLDS(a_chunk_in_buffer, clk, arst_n,
		!inflight_q || (SW'(tail_q) + SW'(len_q) <= SW'(BUF_LEN)))
	`ASSERT_NEVER(a_ptr_range, clk, arst_n,
		(32'(head_q) >= 32'(BUF_LEN)) || (32'(tail_q) >= 32'(BUF_LEN)))
	`ASSERT_HOLDS(a_start_needs_idle, clk, arst_n,
		!(result_valid && result.chunk_started) || result.busy_res)

endmodule

FILE: rtl/trcs_ram.sv
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module trcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
